@@ hdl/hpbm_pkg.sv @@
// ----------------------------------------------------------------------------
// hpbm_pkg: shared types and constants for the hash prefix best-match block
// Field widths, result codes, configuration register indexes and the word
// types passed between pipeline stages.
// ----------------------------------------------------------------------------
package hpbm_pkg;

    // Bytes carried by the hash and target fields
    localparam int FIELD_BYTES = 20;
    localparam int FIELD_BITS  = 8 * FIELD_BYTES;

    // Count widths (up to 32 compared bytes, up to 256 equal bits)
    localparam int BYTES_W  = 6;
    localparam int SUM_W    = 9;
    localparam int BITS_W   = 8;
    localparam int ONES_W   = 4;
    localparam int TAG_W    = 10;
    localparam int TBYTES_W = 5;
    localparam int LETTER_W = 6;

    // Tag remainder arithmetic
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = RECIP_W + TAG_W;
    localparam int REM_W       = 27;

    // State after reset
    localparam logic [BYTES_W-1:0] BEST_BYTES_RESET = 6'd3;
    localparam logic [BITS_W-1:0]  BEST_BITS_RESET  = 8'd24;
    localparam logic [LETTER_W-1:0] MAX_LETTERS     = 6'd32;

    // Result codes
    typedef enum logic [1:0] {
        OUT_NONE   = 2'd0,
        OUT_LONGER = 2'd1,
        OUT_ALT    = 2'd2,
        OUT_FULL   = 2'd3
    } outcome_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TARGET_WORD0   = 3'd0,
        CFG_TARGET_WORD1   = 3'd1,
        CFG_TARGET_WORD2   = 3'd2,
        CFG_TARGET_BYTES   = 3'd3,
        CFG_LAST_BYTE_MASK = 3'd4,
        CFG_PREFIX_LETTERS = 3'd5
    } cfg_reg_t;

    // Merged counts of one word, handed to the decision stage
    typedef struct packed {
        logic [BYTES_W-1:0] match_bytes;
        logic [SUM_W-1:0]   match_bits;
        logic               full;
        logic [TAG_W-1:0]   tag;
    } merge_word_t;

    // Decision stage handshake control
    typedef struct packed {
        logic advance;
        logic take;
    } stage_ctl_t;

endpackage

@@ hdl/hpbm_lane.sv @@
// ----------------------------------------------------------------------------
// hpbm_lane: one byte-position compare lane
// Compares one hash byte with one target byte, under the last-byte mask when
// this lane holds the last compared position, and counts the equal bits.
// ----------------------------------------------------------------------------
module hpbm_lane (
    input  logic [7:0]                  hash_byte,
    input  logic [7:0]                  target_byte,
    input  logic                        active,
    input  logic                        last,
    input  logic [7:0]                  mask,
    output logic                        byte_eq,
    output logic [hpbm_pkg::ONES_W-1:0] ones
);

    logic [7:0]                  lane_mask;
    logic [7:0]                  same;
    logic [hpbm_pkg::ONES_W-1:0] cnt;

    // Full byte unless this is the last compared position
    assign lane_mask = last ? mask : 8'hFF;
    assign same      = ~(hash_byte ^ target_byte) & lane_mask;

    // Popcount of equal bits
    always_comb
    begin
        cnt = '0;
        for (int k = 0; k < 8; k++)
        begin
            cnt = cnt + hpbm_pkg::ONES_W'(same[k]);
        end
    end

    assign byte_eq = active & ((hash_byte & lane_mask) == (target_byte & lane_mask));
    assign ones    = active ? cnt : '0;

endmodule

@@ hdl/hpbm_merge.sv @@
// ----------------------------------------------------------------------------
// hpbm_merge: lane merge stage
// Sums the lane equal-byte flags and equal-bit counts in groups of eight,
// flags a full match and finishes the key tag remainder. Registered output.
// ----------------------------------------------------------------------------
module hpbm_merge #(
    parameter int HASH_BYTES = 20,
    parameter int TAG_COUNT  = 1024
) (
    input  logic                                          clk,
    input  logic                                          load,
    input  logic [HASH_BYTES-1:0]                         lane_eq,
    input  logic [HASH_BYTES-1:0][hpbm_pkg::ONES_W-1:0]   lane_ones,
    input  logic [hpbm_pkg::BYTES_W-1:0]                  len,
    input  logic [hpbm_pkg::TAG_W-1:0]                    tag,
    input  logic [hpbm_pkg::TAG_W-1:0]                    quot,
    output hpbm_pkg::merge_word_t                         merge_word
);

    localparam int GROUPS = (HASH_BYTES + 7) / 8;
    localparam int LANES  = GROUPS * 8;

    logic [LANES-1:0]                        eq_pad;
    logic [LANES-1:0][hpbm_pkg::ONES_W-1:0]  ones_pad;
    logic [hpbm_pkg::BYTES_W-1:0]            grp_bytes [GROUPS];
    logic [hpbm_pkg::SUM_W-1:0]              grp_bits  [GROUPS];
    logic [hpbm_pkg::BYTES_W-1:0]            sum_bytes;
    logic [hpbm_pkg::SUM_W-1:0]              sum_bits;
    logic [hpbm_pkg::REM_W-1:0]              rem_raw;
    logic [hpbm_pkg::REM_W-1:0]              rem_fix;
    hpbm_pkg::merge_word_t                   merge_next;
    hpbm_pkg::merge_word_t                   merge_reg;

    // Pad lanes up to whole groups of eight
    assign eq_pad   = LANES'(lane_eq);
    assign ones_pad = (LANES * hpbm_pkg::ONES_W)'(lane_ones);

    // Group partial sums, then the group total
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_bytes[g] = '0;
            grp_bits[g]  = '0;
            for (int k = 0; k < 8; k++)
            begin
                grp_bytes[g] = grp_bytes[g] + hpbm_pkg::BYTES_W'(eq_pad[g*8+k]);
                grp_bits[g]  = grp_bits[g] + hpbm_pkg::SUM_W'(ones_pad[g*8+k]);
            end
        end
        sum_bytes = '0;
        sum_bits  = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            sum_bytes = sum_bytes + grp_bytes[g];
            sum_bits  = sum_bits + grp_bits[g];
        end
    end

    // Tag remainder: quotient estimate is exact or one low
    assign rem_raw = hpbm_pkg::REM_W'(tag)
                   - hpbm_pkg::REM_W'(quot) * hpbm_pkg::REM_W'(TAG_COUNT);
    assign rem_fix = (rem_raw >= hpbm_pkg::REM_W'(TAG_COUNT))
                   ? rem_raw - hpbm_pkg::REM_W'(TAG_COUNT) : rem_raw;

    always_comb
    begin
        merge_next.match_bytes = sum_bytes;
        merge_next.match_bits  = sum_bits;
        merge_next.full        = (sum_bytes == len);
        merge_next.tag         = rem_fix[hpbm_pkg::TAG_W-1:0];
    end

    // Stage register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            merge_reg <= merge_next;
        end
    end

    assign merge_word = merge_reg;

endmodule

@@ hdl/hpbm_decide.sv @@
// ----------------------------------------------------------------------------
// hpbm_decide: best-match decision stage
// Holds the best byte and bit counts and the done flag, classifies each word
// against them and drives the output register.
// ----------------------------------------------------------------------------
module hpbm_decide #(
    parameter int ALT_MIN_BYTES = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hpbm_pkg::stage_ctl_t              ctl,
    input  hpbm_pkg::merge_word_t             merge_word,
    input  logic [hpbm_pkg::LETTER_W-1:0]     plen,
    output logic                              out_valid,
    output logic [1:0]                        outcome,
    output logic [hpbm_pkg::BYTES_W-1:0]      matched_bytes,
    output logic [hpbm_pkg::BITS_W-1:0]       equal_bits,
    output logic [hpbm_pkg::TAG_W-1:0]        result_tag,
    output logic                              search_done
);

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [hpbm_pkg::BYTES_W-1:0]      best_bytes_reg;
    logic [hpbm_pkg::BYTES_W-1:0]      best_bytes_next;
    logic [hpbm_pkg::BITS_W-1:0]       best_bits_reg;
    logic [hpbm_pkg::BITS_W-1:0]       best_bits_next;
    logic                              found_full_reg;
    logic                              found_full_next;
    hpbm_pkg::outcome_t                outcome_reg;
    hpbm_pkg::outcome_t                outcome_next;
    logic [hpbm_pkg::BYTES_W-1:0]      mbytes_reg;
    logic [hpbm_pkg::BYTES_W-1:0]      mbytes_next;
    logic [hpbm_pkg::BITS_W-1:0]       mbits_reg;
    logic [hpbm_pkg::BITS_W-1:0]       mbits_next;
    logic [hpbm_pkg::TAG_W-1:0]        tag_reg;
    logic                              done_reg;
    logic                              done_next;
    logic [hpbm_pkg::SUM_W-1:0]        best_bits_ext;
    logic                              cand;
    logic                              same_len;

    assign best_bits_ext = hpbm_pkg::SUM_W'(best_bits_reg);
    assign same_len      = (merge_word.match_bytes == best_bytes_reg);
    assign cand          = (merge_word.match_bytes > best_bytes_reg)
                         || ((merge_word.match_bytes > hpbm_pkg::BYTES_W'(ALT_MIN_BYTES))
                             && same_len);

    // Classify the word and update the best-match state
    always_comb
    begin
        best_bytes_next = best_bytes_reg;
        best_bits_next  = best_bits_reg;
        found_full_next = found_full_reg;
        outcome_next    = hpbm_pkg::OUT_NONE;
        mbytes_next     = merge_word.match_bytes;
        mbits_next      = merge_word.match_bits[hpbm_pkg::BITS_W-1:0];
        done_next       = 1'b0;
        out_valid_next  = ctl.advance ? ctl.take : out_valid_reg;

        if (found_full_reg)
        begin
            // search already over
            mbytes_next = '0;
            mbits_next  = '0;
            done_next   = 1'b1;
        end
        else if (merge_word.full)
        begin
            outcome_next = hpbm_pkg::OUT_FULL;
            mbytes_next  = plen;
            done_next    = 1'b1;
            if (ctl.take)
            begin
                best_bytes_next = plen;
                found_full_next = 1'b1;
            end
        end
        else if (cand && (merge_word.match_bits >= best_bits_ext))
        begin
            if (same_len && (merge_word.match_bits <= best_bits_ext))
            begin
                outcome_next = hpbm_pkg::OUT_ALT;
            end
            else
            begin
                outcome_next = hpbm_pkg::OUT_LONGER;
                if (ctl.take)
                begin
                    best_bytes_next = merge_word.match_bytes;
                    if (merge_word.match_bits > best_bits_ext)
                    begin
                        best_bits_next = merge_word.match_bits[hpbm_pkg::BITS_W-1:0];
                    end
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            best_bytes_reg <= hpbm_pkg::BEST_BYTES_RESET;
            best_bits_reg  <= hpbm_pkg::BEST_BITS_RESET;
            found_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            best_bytes_reg <= best_bytes_next;
            best_bits_reg  <= best_bits_next;
            found_full_reg <= found_full_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            outcome_reg <= outcome_next;
            mbytes_reg  <= mbytes_next;
            mbits_reg   <= mbits_next;
            tag_reg     <= merge_word.tag;
            done_reg    <= done_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign outcome       = outcome_reg;
    assign matched_bytes = mbytes_reg;
    assign equal_bits    = mbits_reg;
    assign result_tag    = tag_reg;
    assign search_done   = done_reg;

endmodule

@@ hdl/hash_prefix_best_match_top.sv @@
// ----------------------------------------------------------------------------
// hash_prefix_best_match_top: hash prefix best-match tracker
// Compares each hash with the configured target prefix and reports none,
// new longest, alternative or full match against the best seen so far.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while in_ready is high, and its result word
// reaches the output register through these registered stages: a row of
// HASH_BYTES compare lanes (one per byte position) is registered when the
// word is accepted, a merge stage sums the lane counts and finishes the tag
// remainder into its register, and a decision stage compares against the best
// byte and bit counts and updates them as it loads the output register, so
// back-to-back words always see the state left by the word before. The
// pipeline stalls only when the output register holds a result that is not
// taken and every stage behind it is full. Configuration writes are taken
// every cycle and must only be issued while no word is in flight.
module hash_prefix_best_match_top #(
    parameter int HASH_BYTES    = 20,
    parameter int ALT_MIN_BYTES = 4,
    parameter int TAG_COUNT     = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] hash_word0,
    input  logic [63:0] hash_word1,
    input  logic [31:0] hash_word2,
    input  logic [9:0]  key_tag,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  outcome,
    output logic [5:0]  matched_bytes,
    output logic [7:0]  equal_bits,
    output logic [9:0]  result_tag,
    output logic        search_done
);

    localparam int RECIP = (1 << hpbm_pkg::RECIP_SHIFT) / TAG_COUNT;

    // Configuration registers
    logic [63:0]                         target_word0_reg;
    logic [63:0]                         target_word1_reg;
    logic [31:0]                         target_word2_reg;
    logic [hpbm_pkg::TBYTES_W-1:0]       target_bytes_reg;
    logic [7:0]                          last_byte_mask_reg;
    logic [hpbm_pkg::LETTER_W-1:0]       prefix_letters_reg;

    // Clamped configuration
    logic [hpbm_pkg::BYTES_W-1:0]        len;
    logic [hpbm_pkg::LETTER_W-1:0]       plen;

    // Lane stage
    logic [hpbm_pkg::FIELD_BITS-1:0]             hash_all;
    logic [hpbm_pkg::FIELD_BITS-1:0]             target_all;
    logic [HASH_BYTES-1:0]                       lane_eq;
    logic [HASH_BYTES-1:0][hpbm_pkg::ONES_W-1:0] lane_ones;
    logic [HASH_BYTES-1:0]                       lane_eq_reg;
    logic [HASH_BYTES-1:0][hpbm_pkg::ONES_W-1:0] lane_ones_reg;
    logic [hpbm_pkg::PROD_W-1:0]                 tag_prod;
    logic [hpbm_pkg::TAG_W-1:0]                  tag_reg;
    logic [hpbm_pkg::TAG_W-1:0]                  quot_reg;

    // Pipeline control
    logic                    lane_valid_reg;
    logic                    lane_valid_next;
    logic                    merge_valid_reg;
    logic                    merge_valid_next;
    logic                    lane_adv;
    logic                    merge_adv;
    logic                    out_adv;
    hpbm_pkg::stage_ctl_t    dec_ctl;
    hpbm_pkg::merge_word_t   merge_word;

    // Configuration write decode
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_word0_reg   <= '0;
            target_word1_reg   <= '0;
            target_word2_reg   <= '0;
            target_bytes_reg   <= hpbm_pkg::TBYTES_W'(1);
            last_byte_mask_reg <= 8'hFF;
            prefix_letters_reg <= hpbm_pkg::LETTER_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hpbm_pkg::CFG_TARGET_WORD0:   target_word0_reg   <= cfg_data;
                hpbm_pkg::CFG_TARGET_WORD1:   target_word1_reg   <= cfg_data;
                hpbm_pkg::CFG_TARGET_WORD2:   target_word2_reg   <= cfg_data[31:0];
                hpbm_pkg::CFG_TARGET_BYTES:
                    target_bytes_reg <= cfg_data[hpbm_pkg::TBYTES_W-1:0];
                hpbm_pkg::CFG_LAST_BYTE_MASK: last_byte_mask_reg <= cfg_data[7:0];
                hpbm_pkg::CFG_PREFIX_LETTERS:
                    prefix_letters_reg <= cfg_data[hpbm_pkg::LETTER_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp compare length to 1..HASH_BYTES and letters to 1..32
    always_comb
    begin
        if (target_bytes_reg == '0)
            len = hpbm_pkg::BYTES_W'(1);
        else if (hpbm_pkg::BYTES_W'(target_bytes_reg) > hpbm_pkg::BYTES_W'(HASH_BYTES))
            len = hpbm_pkg::BYTES_W'(HASH_BYTES);
        else
            len = hpbm_pkg::BYTES_W'(target_bytes_reg);

        if (prefix_letters_reg == '0)
            plen = hpbm_pkg::LETTER_W'(1);
        else if (prefix_letters_reg > hpbm_pkg::MAX_LETTERS)
            plen = hpbm_pkg::MAX_LETTERS;
        else
            plen = prefix_letters_reg;
    end

    // Handshake: each stage moves when empty or when the next one moves
    assign out_adv   = !out_valid || out_ready;
    assign merge_adv = !merge_valid_reg || out_adv;
    assign lane_adv  = !lane_valid_reg || merge_adv;
    assign in_ready  = lane_adv;

    assign lane_valid_next  = lane_adv ? in_valid : lane_valid_reg;
    assign merge_valid_next = merge_adv ? lane_valid_reg : merge_valid_reg;
    assign dec_ctl.advance  = out_adv;
    assign dec_ctl.take     = merge_valid_reg && out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg  <= 1'b0;
            merge_valid_reg <= 1'b0;
        end
        else
        begin
            lane_valid_reg  <= lane_valid_next;
            merge_valid_reg <= merge_valid_next;
        end
    end

    // Compare lanes, byte 0 in the top bits
    assign hash_all   = {hash_word0, hash_word1, hash_word2};
    assign target_all = {target_word0_reg, target_word1_reg, target_word2_reg};

    for (genvar i = 0; i < HASH_BYTES; i++)
    begin : g_lane
        logic [7:0] hb;
        logic [7:0] tb;

        // positions past the hash field read as zero
        if (i < hpbm_pkg::FIELD_BYTES)
        begin : g_field
            assign hb = hash_all[hpbm_pkg::FIELD_BITS-1-8*i -: 8];
            assign tb = target_all[hpbm_pkg::FIELD_BITS-1-8*i -: 8];
        end
        else
        begin : g_zero
            assign hb = 8'h00;
            assign tb = 8'h00;
        end

        hpbm_lane u_lane (
            .hash_byte   (hb),
            .target_byte (tb),
            .active      (hpbm_pkg::BYTES_W'(i) < len),
            .last        (hpbm_pkg::BYTES_W'(i + 1) == len),
            .mask        (last_byte_mask_reg),
            .byte_eq     (lane_eq[i]),
            .ones        (lane_ones[i])
        );
    end

    // Tag quotient estimate by reciprocal multiply
    assign tag_prod = hpbm_pkg::PROD_W'(key_tag) * hpbm_pkg::PROD_W'(RECIP);

    // Lane result register
    always_ff @(posedge clk)
    begin
        if (lane_adv)
        begin
            lane_eq_reg   <= lane_eq;
            lane_ones_reg <= lane_ones;
            tag_reg       <= key_tag;
            quot_reg      <= tag_prod[hpbm_pkg::RECIP_SHIFT+hpbm_pkg::TAG_W-1:
                                      hpbm_pkg::RECIP_SHIFT];
        end
    end

    // Merge stage
    hpbm_merge #(
        .HASH_BYTES (HASH_BYTES),
        .TAG_COUNT  (TAG_COUNT)
    ) u_merge (
        .clk        (clk),
        .load       (merge_adv),
        .lane_eq    (lane_eq_reg),
        .lane_ones  (lane_ones_reg),
        .len        (len),
        .tag        (tag_reg),
        .quot       (quot_reg),
        .merge_word (merge_word)
    );

    // Decision stage and output register
    hpbm_decide #(
        .ALT_MIN_BYTES (ALT_MIN_BYTES)
    ) u_decide (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (dec_ctl),
        .merge_word    (merge_word),
        .plen          (plen),
        .out_valid     (out_valid),
        .outcome       (outcome),
        .matched_bytes (matched_bytes),
        .equal_bits    (equal_bits),
        .result_tag    (result_tag),
        .search_done   (search_done)
    );

endmodule

@@ hdl/hpbm_check.sv @@
// ----------------------------------------------------------------------------
// hpbm_check: port-level checks for the hash prefix best-match block
// Watches the result channel: the done flag is sticky, a full match reports
// done, other finished-search words carry zero counts, stalled words hold.
// ----------------------------------------------------------------------------
module hpbm_check (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] outcome,
    input logic [5:0] matched_bytes,
    input logic [7:0] equal_bits,
    input logic       search_done
);

    logic done_seen_reg;
    logic done_seen_next;

    // Remember a delivered done word
    assign done_seen_next = done_seen_reg || (out_valid && out_ready && search_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_seen_reg <= 1'b0;
        else
            done_seen_reg <= done_seen_next;
    end

    // Once done, every later word reports done with no match
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_seen_reg) |->
            (search_done && (outcome == hpbm_pkg::OUT_NONE)))
        else $error("word after a full match not reported as done");

    // Full match always reports done
    a_full_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome == hpbm_pkg::OUT_FULL)) |-> search_done)
        else $error("full match without done flag");

    // Finished-search words other than a full match carry zero counts
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && search_done && (outcome != hpbm_pkg::OUT_FULL)) |->
            ((matched_bytes == 6'd0) && (equal_bits == 8'd0)
             && (outcome == hpbm_pkg::OUT_NONE)))
        else $error("done word with nonzero counts");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(outcome) && $stable(matched_bytes)
             && $stable(equal_bits) && $stable(search_done)))
        else $error("result word changed while stalled");

endmodule

bind hash_prefix_best_match_top hpbm_check u_hpbm_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .outcome       (outcome),
    .matched_bytes (matched_bytes),
    .equal_bits    (equal_bits),
    .search_done   (search_done)
);
